// ===== rtl/tdr_pkg.sv =====
// Shared constants, types and a helper function for the triangle depth rasterizer.
// Used by the arithmetic unit, the top level and the testbench.
`default_nettype none

package tdr_pkg;

  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;
  localparam int DEPTH        = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int COL_W        = $clog2(FRAME_WIDTH);
  localparam int ROW_W        = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int LIMW_W       = $clog2(FRAME_WIDTH + 1);
  localparam int LIMH_W       = $clog2(FRAME_HEIGHT + 1);

  localparam logic [31:0] FAR_DEPTH = 32'hFFFF_FFFF;
  localparam logic [18:0] COUNT_MAX = 19'h7FFFF;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef logic signed [63:0] wide_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'b01,
    ALU_DIV = 2'b10
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    wide_t   a;
    wide_t   b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    wide_t result;
  } alu_rsp_t;

  // Division by 65536 with truncation toward zero.
  function automatic wide_t trunc_q16(input wide_t v);
    wide_t adj;
    adj = v[63] ? v + 64'sd65535 : v;
    return adj >>> 16;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdr_if.sv =====
// Valid/ready channel interfaces for commands, results and register writes.
`default_nettype none

interface tdr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [15:0] vert_a_x;
  logic signed [15:0] vert_a_y;
  logic [31:0] vert_a_invz;
  logic signed [15:0] vert_b_x;
  logic signed [15:0] vert_b_y;
  logic [31:0] vert_b_invz;
  logic signed [15:0] vert_c_x;
  logic signed [15:0] vert_c_y;
  logic [31:0] vert_c_invz;
  logic [8:0]  read_col;
  logic [8:0]  read_row;
  modport source (output valid, command, vert_a_x, vert_a_y, vert_a_invz, vert_b_x,
                  vert_b_y, vert_b_invz, vert_c_x, vert_c_y, vert_c_invz, read_col,
                  read_row, input ready);
  modport sink (input valid, command, vert_a_x, vert_a_y, vert_a_invz, vert_b_x,
                vert_b_y, vert_b_invz, vert_c_x, vert_c_y, vert_c_invz, read_col,
                read_row, output ready);
endinterface

interface tdr_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_depth;
  logic [18:0] pixels_written;
  modport source (output valid, read_depth, pixels_written, input ready);
  modport sink (input valid, read_depth, pixels_written, output ready);
endinterface

interface tdr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdr_alu.sv =====
// Shared iterative arithmetic unit: 64-bit signed divide, one quotient bit per
// cycle, and 64 by 17 bit shift-add multiply. Depends on tdr_pkg.
`default_nettype none

module tdr_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tdr_pkg::alu_req_t req,
  output tdr_pkg::alu_rsp_t      rsp
);

  logic             busy;
  tdr_pkg::alu_op_t op_r;
  logic [6:0]       cnt;
  logic [63:0]      rem;
  logic [63:0]      quo;
  logic [63:0]      dmag;
  logic             neg;
  logic             zero_den;
  tdr_pkg::wide_t   mcand;
  logic [16:0]      mplier;
  tdr_pkg::wide_t   acc;
  logic             done_r;
  tdr_pkg::wide_t   res_r;

  logic [64:0]      rem_sh;
  logic [63:0]      rem_next;
  logic [63:0]      quo_next;
  tdr_pkg::wide_t   acc_next;

  always_comb begin
    rem_sh = {rem, quo[63]};
    if (rem_sh >= {1'b0, dmag}) begin
      rem_next = 64'(rem_sh - {1'b0, dmag});
      quo_next = {quo[62:0], 1'b1};
    end else begin
      rem_next = rem_sh[63:0];
      quo_next = {quo[62:0], 1'b0};
    end
    acc_next = mplier[0] ? acc + mcand : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= '0;
        quo  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        dmag <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        rem  <= '0;
        neg  <= req.a[63] ^ req.b[63];
        zero_den <= (req.b == 64'sd0);
        mcand  <= req.a;
        mplier <= req.b[16:0];
        acc    <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (op_r == tdr_pkg::ALU_DIV) begin
          rem <= rem_next;
          quo <= quo_next;
          if (cnt == 7'd63) begin
            busy   <= 1'b0;
            done_r <= 1'b1;
            if (zero_den) begin
              res_r <= '0;
            end else begin
              res_r <= neg ? -$signed(quo_next) : $signed(quo_next);
            end
          end
        end else begin
          acc    <= acc_next;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          if (cnt == 7'd16) begin
            busy   <= 1'b0;
            done_r <= 1'b1;
            res_r  <= acc_next;
          end
        end
      end
    end
  end

  assign rsp = '{done: done_r, result: res_r};

endmodule

`default_nettype wire

// ===== rtl/triangle_depth_rasterizer.sv =====
// Top level of the triangle depth rasterizer: command sequencer and depth store.
// Depends on tdr_pkg, the channel interfaces and tdr_alu.
// Clear fills the store with FAR_DEPTH, read passes through S_READ and S_READ2, command 3 only reports.
// A draw runs a setup, then walks each row and each covered pixel, using the shared
// divider and multiplier for every quotient and product.
// One item is worked at a time; reset runs a clearing pass first.
`default_nettype none

module triangle_depth_rasterizer (
  input  wire logic  clk,
  input  wire logic  rst,
  tdr_cmd_if.sink    cmd,
  tdr_res_if.source  result,
  tdr_cfg_if.sink    cfg
);

  typedef enum logic [25:0] {
    S_IDLE    = 26'd1 << 0,
    S_CLEAR   = 26'd1 << 1,
    S_READ    = 26'd1 << 2,
    S_READ2   = 26'd1 << 3,
    S_SETUP   = 26'd1 << 4,
    S_X4B     = 26'd1 << 5,
    S_X4C     = 26'd1 << 6,
    S_Z4A     = 26'd1 << 7,
    S_Z4B     = 26'd1 << 8,
    S_Z4C     = 26'd1 << 9,
    S_PART    = 26'd1 << 10,
    S_SLOPE   = 26'd1 << 11,
    S_SWAP    = 26'd1 << 12,
    S_EDGE    = 26'd1 << 13,
    S_ROW     = 26'd1 << 14,
    S_PIX0    = 26'd1 << 15,
    S_TCL     = 26'd1 << 16,
    S_M1      = 26'd1 << 17,
    S_M2      = 26'd1 << 18,
    S_RCP     = 26'd1 << 19,
    S_DCL     = 26'd1 << 20,
    S_PIXW    = 26'd1 << 21,
    S_ROWEND  = 26'd1 << 22,
    S_PARTEND = 26'd1 << 23,
    S_DONE    = 26'd1 << 24,
    S_WAIT    = 26'd1 << 25
  } state_t;

  localparam int AW = tdr_pkg::ADDR_W;

  state_t state;
  state_t ret;

  logic [9:0] width_reg;
  logic [9:0] height_reg;

  logic [31:0] mem [tdr_pkg::DEPTH];
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [AW-1:0] clr_addr;
  logic          clr_report;
  logic          rd_oob;

  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic [31:0]        vz [3];
  logic [tdr_pkg::LIMW_W-1:0] limw;
  logic [tdr_pkg::LIMH_W-1:0] limh;

  tdr_pkg::wide_t x4;
  tdr_pkg::wide_t z4;
  tdr_pkg::wide_t t1;
  tdr_pkg::wide_t sl [4];
  tdr_pkg::wide_t ed [4];
  logic [2:0]     j;
  logic           part;
  logic [tdr_pkg::ROW_W-1:0] cy;
  logic [tdr_pkg::ROW_W-1:0] c1r;
  logic [16:0]    k0;
  logic [tdr_pkg::COL_W-1:0] ax;
  logic [tdr_pkg::COL_W-1:0] hi;
  logic [16:0]    tq;
  logic [31:0]    dq;
  logic [18:0]    count;
  logic [31:0]    rdr;

  logic           out_valid;
  logic [31:0]    out_depth;
  logic [18:0]    out_count;

  tdr_pkg::alu_req_t alu_req;
  tdr_pkg::alu_rsp_t alu_rsp;

  logic signed [15:0] sx [3];
  logic signed [15:0] sy [3];
  logic [31:0]        sz [3];
  logic [tdr_pkg::LIMW_W-1:0] limw_v;
  logic [tdr_pkg::LIMH_W-1:0] limh_v;

  tdr_pkg::wide_t xw [3];
  tdr_pkg::wide_t yw [3];
  tdr_pkg::wide_t zw [3];
  tdr_pkg::wide_t dy02, dy01, dy12, dyp, ylimh, wlim;
  tdr_pkg::wide_t slope_num, base_v, c0v, c1v, k0v, lo_v, hi_v, px_num, px_den, iz_v;
  tdr_pkg::wide_t res;
  logic [1:0]     jm1;
  logic [AW-1:0]  pix_addr;

  tdr_alu u_alu (.clk(clk), .rst(rst), .req(alu_req), .rsp(alu_rsp));

  assign res = alu_rsp.result;

  always_comb begin
    logic signed [15:0] tx, ty;
    logic [31:0]        tz;
    tx = '0;
    ty = '0;
    tz = '0;
    sx[0] = cmd.vert_a_x; sy[0] = cmd.vert_a_y; sz[0] = cmd.vert_a_invz;
    sx[1] = cmd.vert_b_x; sy[1] = cmd.vert_b_y; sz[1] = cmd.vert_b_invz;
    sx[2] = cmd.vert_c_x; sy[2] = cmd.vert_c_y; sz[2] = cmd.vert_c_invz;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; tz = sz[0];
      sx[0] = sx[1]; sy[0] = sy[1]; sz[0] = sz[1];
      sx[1] = tx; sy[1] = ty; sz[1] = tz;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; tz = sz[1];
      sx[1] = sx[2]; sy[1] = sy[2]; sz[1] = sz[2];
      sx[2] = tx; sy[2] = ty; sz[2] = tz;
    end
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; tz = sz[0];
      sx[0] = sx[1]; sy[0] = sy[1]; sz[0] = sz[1];
      sx[1] = tx; sy[1] = ty; sz[1] = tz;
    end
  end

  always_comb begin
    if (width_reg == 10'd0) begin
      limw_v = tdr_pkg::LIMW_W'(1);
    end else if (32'(width_reg) > 32'(tdr_pkg::FRAME_WIDTH)) begin
      limw_v = tdr_pkg::LIMW_W'(tdr_pkg::FRAME_WIDTH);
    end else begin
      limw_v = tdr_pkg::LIMW_W'(width_reg);
    end
    if (height_reg == 10'd0) begin
      limh_v = tdr_pkg::LIMH_W'(1);
    end else if (32'(height_reg) > 32'(tdr_pkg::FRAME_HEIGHT)) begin
      limh_v = tdr_pkg::LIMH_W'(tdr_pkg::FRAME_HEIGHT);
    end else begin
      limh_v = tdr_pkg::LIMH_W'(height_reg);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xw[i] = tdr_pkg::wide_t'(vx[i]);
      yw[i] = tdr_pkg::wide_t'(vy[i]);
      zw[i] = $signed({32'd0, vz[i]});
    end
    dy02  = yw[2] - yw[0];
    dy01  = yw[1] - yw[0];
    dy12  = yw[2] - yw[1];
    dyp   = part ? dy12 : dy01;
    ylimh = $signed({{(64 - tdr_pkg::LIMH_W){1'b0}}, limh});
    wlim  = $signed({{(64 - tdr_pkg::LIMW_W){1'b0}}, limw});
    jm1   = 2'(j - 3'd1);

    case (j[1:0])
      2'd0:    slope_num = part ? (xw[2] - xw[1]) <<< 16 : (xw[1] - xw[0]) <<< 16;
      2'd1:    slope_num = part ? (xw[2] - x4) <<< 16 : (x4 - xw[0]) <<< 16;
      2'd2:    slope_num = part ? (zw[2] - zw[1]) <<< 8 : (zw[1] - zw[0]) <<< 8;
      default: slope_num = part ? (zw[2] - z4) <<< 8 : (z4 - zw[0]) <<< 8;
    endcase

    if (jm1[1]) begin
      base_v = part ? zw[2] <<< 8 : zw[0] <<< 8;
    end else begin
      base_v = part ? xw[2] <<< 16 : xw[0] <<< 16;
    end

    if (part) begin
      c0v = (yw[1] + 64'sd1 < 64'sd0) ? 64'sd0 : yw[1] + 64'sd1;
      c1v = (yw[2] > ylimh - 64'sd1) ? ylimh - 64'sd1 : yw[2];
      k0v = yw[2] - c0v;
      lo_v = tdr_pkg::trunc_q16(ed[0]);
      hi_v = tdr_pkg::trunc_q16(ed[1]);
    end else begin
      c0v = (yw[0] < 64'sd0) ? 64'sd0 : yw[0];
      c1v = (yw[1] > ylimh - 64'sd1) ? ylimh - 64'sd1 : yw[1];
      k0v = c0v - yw[0];
      lo_v = tdr_pkg::trunc_q16(ed[1]);
      hi_v = tdr_pkg::trunc_q16(ed[0]);
    end
    if (lo_v < 64'sd0) lo_v = 64'sd0;
    if (hi_v > wlim - 64'sd1) hi_v = wlim - 64'sd1;

    px_num = ($signed({{(64 - tdr_pkg::COL_W){1'b0}}, ax}) <<< 16) - ed[1];
    px_den = ed[0] - ed[1];
    iz_v   = tdr_pkg::trunc_q16(t1 + res);
    pix_addr = AW'(AW'(cy) * AW'(tdr_pkg::FRAME_WIDTH) + AW'(ax));
  end

  always_comb begin
    alu_req = '{start: 1'b0, op: tdr_pkg::ALU_MUL, a: '0, b: '0};
    case (state)
      S_SETUP: begin
        if (yw[0] < ylimh && yw[2] >= 64'sd0) begin
          alu_req = '{start: 1'b1, op: tdr_pkg::ALU_MUL, a: xw[0], b: dy02};
        end
      end
      S_X4B: alu_req = '{start: 1'b1, op: tdr_pkg::ALU_MUL, a: xw[2] - xw[0], b: dy01};
      S_X4C: alu_req = '{start: 1'b1, op: tdr_pkg::ALU_DIV, a: t1 + res, b: dy02};
      S_Z4A: alu_req = '{start: 1'b1, op: tdr_pkg::ALU_MUL, a: zw[2] - zw[0], b: dy01};
      S_Z4B: alu_req = '{start: 1'b1, op: tdr_pkg::ALU_DIV, a: res, b: dy02};
      S_SLOPE: begin
        if (j != 3'd4) begin
          alu_req = '{start: 1'b1, op: tdr_pkg::ALU_DIV, a: slope_num, b: dyp};
        end
      end
      S_EDGE: begin
        if (j != 3'd4) begin
          alu_req = '{start: 1'b1, op: tdr_pkg::ALU_MUL, a: sl[j[1:0]],
                      b: $signed({47'd0, k0})};
        end
      end
      S_PIX0: begin
        if (px_den != 64'sd0) begin
          alu_req = '{start: 1'b1, op: tdr_pkg::ALU_DIV, a: px_num <<< 16, b: px_den};
        end
      end
      S_M1: alu_req = '{start: 1'b1, op: tdr_pkg::ALU_MUL, a: ed[3],
                        b: $signed({47'd0, 17'(tdr_pkg::ONE_Q16 - tq)})};
      S_M2: alu_req = '{start: 1'b1, op: tdr_pkg::ALU_MUL, a: ed[2],
                        b: $signed({47'd0, tq})};
      S_RCP: begin
        if (iz_v > 64'sd0) begin
          alu_req = '{start: 1'b1, op: tdr_pkg::ALU_DIV, a: 64'sd1 <<< 48, b: iz_v};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = pix_addr;
    wdata  = dq;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      waddr  = clr_addr;
      wdata  = tdr_pkg::FAR_DEPTH;
    end else if (state == S_PIXW && dq < rdata) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 10'd512;
      height_reg <= 10'd512;
    end else if (cfg.valid) begin
      if (cfg.index == tdr_pkg::CFG_WIDTH) begin
        width_reg <= cfg.data;
      end else if (cfg.index == tdr_pkg::CFG_HEIGHT) begin
        height_reg <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ret        <= S_IDLE;
      out_valid  <= 1'b0;
      clr_addr   <= '0;
      clr_report <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            count <= '0;
            rdr   <= '0;
            case (cmd.command)
              tdr_pkg::CMD_CLEAR: begin
                clr_addr   <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              tdr_pkg::CMD_DRAW: begin
                vx   <= sx;
                vy   <= sy;
                vz   <= sz;
                limw <= limw_v;
                limh <= limh_v;
                state <= S_SETUP;
              end
              tdr_pkg::CMD_READ: begin
                raddr  <= AW'(AW'(cmd.read_row) * AW'(tdr_pkg::FRAME_WIDTH)
                              + AW'(cmd.read_col));
                rd_oob <= (32'(cmd.read_col) >= 32'(tdr_pkg::FRAME_WIDTH)) ||
                          (32'(cmd.read_row) >= 32'(tdr_pkg::FRAME_HEIGHT));
                state  <= S_READ;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          count    <= '0;
          rdr      <= '0;
          if (clr_addr == AW'(tdr_pkg::DEPTH - 1)) begin
            state <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_READ: state <= S_READ2;
        S_READ2: begin
          rdr   <= rd_oob ? tdr_pkg::FAR_DEPTH : rdata;
          state <= S_DONE;
        end
        S_SETUP: begin
          if (yw[0] < ylimh && yw[2] >= 64'sd0) begin
            ret   <= S_X4B;
            state <= S_WAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_X4B: begin
          t1    <= res;
          ret   <= S_X4C;
          state <= S_WAIT;
        end
        S_X4C: begin
          ret   <= S_Z4A;
          state <= S_WAIT;
        end
        S_Z4A: begin
          x4    <= (dy02 == 64'sd0) ? xw[0] : res;
          ret   <= S_Z4B;
          state <= S_WAIT;
        end
        S_Z4B: begin
          ret   <= S_Z4C;
          state <= S_WAIT;
        end
        S_Z4C: begin
          z4    <= zw[0] + res;
          part  <= 1'b0;
          state <= S_PART;
        end
        S_PART: begin
          j     <= '0;
          state <= S_SLOPE;
        end
        S_SLOPE: begin
          if (j != 3'd0) begin
            sl[jm1] <= res;
          end
          if (j == 3'd4) begin
            state <= S_SWAP;
          end else begin
            j     <= j + 3'd1;
            ret   <= S_SLOPE;
            state <= S_WAIT;
          end
        end
        S_SWAP: begin
          if (sl[0] < sl[1]) begin
            sl[0] <= sl[1];
            sl[1] <= sl[0];
            sl[2] <= sl[3];
            sl[3] <= sl[2];
          end
          if (c0v > c1v) begin
            state <= S_PARTEND;
          end else begin
            cy    <= tdr_pkg::ROW_W'(c0v);
            c1r   <= tdr_pkg::ROW_W'(c1v);
            k0    <= 17'(k0v);
            j     <= '0;
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (j != 3'd0) begin
            ed[jm1] <= part ? base_v - res : base_v + res;
          end
          if (j == 3'd4) begin
            state <= S_ROW;
          end else begin
            j     <= j + 3'd1;
            ret   <= S_EDGE;
            state <= S_WAIT;
          end
        end
        S_ROW: begin
          if (lo_v > hi_v) begin
            state <= S_ROWEND;
          end else begin
            ax    <= tdr_pkg::COL_W'(lo_v);
            hi    <= tdr_pkg::COL_W'(hi_v);
            state <= S_PIX0;
          end
        end
        S_PIX0: begin
          raddr <= pix_addr;
          if (px_den == 64'sd0) begin
            tq    <= tdr_pkg::ONE_Q16;
            state <= S_M1;
          end else begin
            ret   <= S_TCL;
            state <= S_WAIT;
          end
        end
        S_TCL: begin
          if (res < 64'sd0) begin
            tq <= '0;
          end else if (res > 64'sd65536) begin
            tq <= tdr_pkg::ONE_Q16;
          end else begin
            tq <= res[16:0];
          end
          state <= S_M1;
        end
        S_M1: begin
          ret   <= S_M2;
          state <= S_WAIT;
        end
        S_M2: begin
          t1    <= res;
          ret   <= S_RCP;
          state <= S_WAIT;
        end
        S_RCP: begin
          if (iz_v > 64'sd0) begin
            ret   <= S_DCL;
            state <= S_WAIT;
          end else begin
            dq    <= tdr_pkg::FAR_DEPTH;
            state <= S_PIXW;
          end
        end
        S_DCL: begin
          dq    <= (res[63:32] != 32'd0) ? tdr_pkg::FAR_DEPTH : res[31:0];
          state <= S_PIXW;
        end
        S_PIXW: begin
          if (dq < rdata && count != tdr_pkg::COUNT_MAX) begin
            count <= count + 19'd1;
          end
          if (ax == hi) begin
            state <= S_ROWEND;
          end else begin
            ax    <= ax + tdr_pkg::COL_W'(1);
            state <= S_PIX0;
          end
        end
        S_ROWEND: begin
          for (int i = 0; i < 4; i++) begin
            ed[i] <= ed[i] + sl[i];
          end
          if (cy == c1r) begin
            state <= S_PARTEND;
          end else begin
            cy    <= cy + tdr_pkg::ROW_W'(1);
            state <= S_ROW;
          end
        end
        S_PARTEND: begin
          if (!part) begin
            part  <= 1'b1;
            state <= S_PART;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_depth <= rdr;
            out_count <= count;
            state     <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready             = (state == S_IDLE);
  assign cfg.ready             = 1'b1;
  assign result.valid          = out_valid;
  assign result.read_depth     = out_depth;
  assign result.pixels_written = out_count;

endmodule

`default_nettype wire

// ===== rtl/tdr_checker.sv =====
// Port-level checks for the triangle depth rasterizer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module tdr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] read_depth,
  input wire logic [18:0] pixels_written
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped before it was taken");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    res_valid && pixels_written != 19'd0 |-> read_depth == 32'd0)
    else $error("draw item carries a read depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while previous item in work");

endmodule

bind triangle_depth_rasterizer tdr_checker u_tdr_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .read_depth(result.read_depth),
  .pixels_written(result.pixels_written)
);

`default_nettype wire

// ===== dv/tb_triangle_depth_rasterizer.sv =====
// Self-checking testbench for triangle_depth_rasterizer: directed and random commands,
// each result checked against an in-bench depth-store model of clear, draw and read.
// Depends on tdr_pkg, the channel interfaces in tdr_if.sv and the RTL top level.
`timescale 1ns / 1ps

module tb_triangle_depth_rasterizer;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] vx [3];
    logic signed [15:0] vy [3];
    logic [31:0]        vz [3];
    logic [8:0]         col;
    logic [8:0]         row;
  } raster_cmd_t;

  typedef struct {
    logic [31:0] depth;
    logic [18:0] count;
  } raster_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdr_cmd_if cmd ();
  tdr_res_if result ();
  tdr_cfg_if cfg ();

  triangle_depth_rasterizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  always #6 clk = ~clk;

  logic [31:0]  depth_model [tdr_pkg::DEPTH];
  logic [9:0]   width_reg;
  logic [9:0]   height_reg;
  longint       lim_w;
  longint       lim_h;
  int unsigned  draw_count;
  raster_res_t  pending_q [$];
  int           mismatches;
  int           hold_seq;
  int           hold_cycles;
  int           hot_col [$];
  int           hot_row [$];

  function automatic longint ratio_div(longint num, longint den);
    return den == 0 ? 0 : num / den;
  endfunction

  function automatic void shade_row(longint cy, longint xa, longint xb, longint za,
                                    longint zb, longint lo, longint hi);
    longint ax, num, den, t, iz, d;
    int unsigned idx;
    if (cy < 0 || cy >= lim_h) return;
    if (lo < 0) lo = 0;
    if (hi > lim_w - 1) hi = lim_w - 1;
    for (ax = lo; ax <= hi; ax++) begin
      den = xa - xb;
      num = ax * 65536 - xb;
      if (den == 0) begin
        t = 65536;
      end else begin
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        t = num * 65536 / den;
        if (t < 0) t = 0;
        if (t > 65536) t = 65536;
      end
      iz = ((65536 - t) * zb + t * za) / 65536;
      if (iz <= 0) begin
        d = 64'hFFFF_FFFF;
      end else begin
        d = (longint'(1) <<< 48) / iz;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      end
      idx = int'(cy) * tdr_pkg::FRAME_WIDTH + int'(ax);
      if (d < longint'({32'd0, depth_model[idx]})) begin
        depth_model[idx] = d[31:0];
        if (draw_count < tdr_pkg::COUNT_MAX) draw_count++;
      end
    end
  endfunction

  function automatic void draw_model(raster_cmd_t c);
    longint x[3], y[3], z[3], tx, ty, tz;
    longint x4, z4, dy, s1, s2, sz1, sz2, cy, k, e1, e2;
    int i;
    for (i = 0; i < 3; i++) begin
      x[i] = c.vx[i];
      y[i] = c.vy[i];
      z[i] = {32'd0, c.vz[i]};
    end
    for (int p = 0; p < 3; p++) begin
      i = (p == 1) ? 1 : 0;
      if (y[i] > y[i+1]) begin
        tx = x[i]; ty = y[i]; tz = z[i];
        x[i] = x[i+1]; y[i] = y[i+1]; z[i] = z[i+1];
        x[i+1] = tx; y[i+1] = ty; z[i+1] = tz;
      end
    end
    if (!(y[0] < lim_h && y[2] >= 0)) return;
    dy = y[2] - y[0];
    x4 = ratio_div(x[0] * dy + (y[1] - y[0]) * (x[2] - x[0]), dy);
    if (dy == 0) x4 = x[0];
    z4 = z[0] + ratio_div((y[1] - y[0]) * (z[2] - z[0]), dy);

    dy = y[1] - y[0];
    s1 = ratio_div((x[1] - x[0]) * 65536, dy);
    s2 = ratio_div((x4 - x[0]) * 65536, dy);
    sz1 = ratio_div((z[1] - z[0]) * 256, dy);
    sz2 = ratio_div((z4 - z[0]) * 256, dy);
    if (s1 < s2) begin
      tx = s1; s1 = s2; s2 = tx;
      tz = sz1; sz1 = sz2; sz2 = tz;
    end
    for (cy = (y[0] < 0 ? 0 : y[0]); cy <= (y[1] > lim_h - 1 ? lim_h - 1 : y[1]); cy++) begin
      k = cy - y[0];
      e1 = x[0] * 65536 + s1 * k;
      e2 = x[0] * 65536 + s2 * k;
      shade_row(cy, e1, e2, z[0] * 256 + sz1 * k, z[0] * 256 + sz2 * k,
                e2 / 65536, e1 / 65536);
    end

    dy = y[2] - y[1];
    s1 = ratio_div((x[2] - x[1]) * 65536, dy);
    s2 = ratio_div((x[2] - x4) * 65536, dy);
    sz1 = ratio_div((z[2] - z[1]) * 256, dy);
    sz2 = ratio_div((z[2] - z4) * 256, dy);
    if (s1 < s2) begin
      tx = s1; s1 = s2; s2 = tx;
      tz = sz1; sz1 = sz2; sz2 = tz;
    end
    for (cy = (y[1] + 1 < 0 ? 0 : y[1] + 1); cy <= (y[2] > lim_h - 1 ? lim_h - 1 : y[2]);
         cy++) begin
      k = y[2] - cy;
      e1 = x[2] * 65536 - s1 * k;
      e2 = x[2] * 65536 - s2 * k;
      shade_row(cy, e1, e2, z[2] * 256 - sz1 * k, z[2] * 256 - sz2 * k,
                e1 / 65536, e2 / 65536);
    end
  endfunction

  function automatic raster_res_t predict(raster_cmd_t c);
    raster_res_t r;
    r.depth = '0;
    r.count = '0;
    case (c.op)
      tdr_pkg::CMD_CLEAR: begin
        for (int i = 0; i < tdr_pkg::DEPTH; i++) depth_model[i] = tdr_pkg::FAR_DEPTH;
      end
      tdr_pkg::CMD_DRAW: begin
        lim_w = width_reg < 1 ? 1 : (width_reg > tdr_pkg::FRAME_WIDTH ?
                                     tdr_pkg::FRAME_WIDTH : width_reg);
        lim_h = height_reg < 1 ? 1 : (height_reg > tdr_pkg::FRAME_HEIGHT ?
                                      tdr_pkg::FRAME_HEIGHT : height_reg);
        draw_count = 0;
        draw_model(c);
        r.count = draw_count[18:0];
      end
      tdr_pkg::CMD_READ: begin
        r.depth = depth_model[int'(c.row) * tdr_pkg::FRAME_WIDTH + int'(c.col)];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 150);
  endfunction

  // Result side: checks every accepted item and drives ready with random gaps and hold periods.
  int gap_left;
  int hold_left;
  int hold_seen;
  always @(posedge clk) begin
    raster_res_t e;
    if (result.valid && result.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result depth=%h count=%0d",
                                       result.read_depth, result.pixels_written);
      end else begin
        e = pending_q.pop_front();
        if (result.read_depth !== e.depth || result.pixels_written !== e.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected depth=%h count=%0d, got depth=%h count=%0d",
                     e.depth, e.count, result.read_depth, result.pixels_written);
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_cycles;
    end
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
    end
  end

  task automatic send_item(raster_cmd_t c, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : pick_gap();
    if (g > 0) begin
      cmd.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.command     <= c.op;
    cmd.vert_a_x    <= c.vx[0];
    cmd.vert_a_y    <= c.vy[0];
    cmd.vert_a_invz <= c.vz[0];
    cmd.vert_b_x    <= c.vx[1];
    cmd.vert_b_y    <= c.vy[1];
    cmd.vert_b_invz <= c.vz[1];
    cmd.vert_c_x    <= c.vx[2];
    cmd.vert_c_y    <= c.vy[2];
    cmd.vert_c_invz <= c.vz[2];
    cmd.read_col    <= c.col;
    cmd.read_row    <= c.row;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pending_q.push_back(predict(c));
  endtask

  task automatic wait_idle();
    cmd.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == tdr_pkg::CFG_WIDTH) width_reg = val;
    else if (idx == tdr_pkg::CFG_HEIGHT) height_reg = val;
  endtask

  task automatic set_frame(logic [9:0] w, logic [9:0] h);
    wait_idle();
    write_reg(tdr_pkg::CFG_WIDTH, w);
    write_reg(tdr_pkg::CFG_HEIGHT, h);
    cfg.valid <= 1'b0;
  endtask

  function automatic raster_cmd_t make_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                           logic [31:0] z0, logic [31:0] z1, logic [31:0] z2);
    raster_cmd_t c;
    c.op = tdr_pkg::CMD_DRAW;
    c.vx[0] = 16'(x0); c.vy[0] = 16'(y0); c.vz[0] = z0;
    c.vx[1] = 16'(x1); c.vy[1] = 16'(y1); c.vz[1] = z1;
    c.vx[2] = 16'(x2); c.vy[2] = 16'(y2); c.vz[2] = z2;
    c.col = 9'($urandom);
    c.row = 9'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t make_read(int col, int row);
    raster_cmd_t c;
    c = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    c.op = tdr_pkg::CMD_READ;
    c.col = 9'(col);
    c.row = 9'(row);
    return c;
  endfunction

  function automatic logic [31:0] rand_invz();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 32'd0;
    if (p < 3) return $urandom;
    return $urandom_range(32'h0010_0000, 32'h1000_0000);
  endfunction

  function automatic raster_cmd_t rand_small_tri(int span);
    int bx, by;
    raster_cmd_t c;
    bx = $urandom_range(0, 521) - 5;
    by = $urandom_range(0, 521) - 5;
    c = make_tri(bx + $urandom_range(0, span), by + $urandom_range(0, span),
                 bx + $urandom_range(0, span), by + $urandom_range(0, span),
                 bx + $urandom_range(0, span), by + $urandom_range(0, span),
                 rand_invz(), rand_invz(), rand_invz());
    hot_col.push_back(bx < 0 ? 0 : bx % 512);
    hot_row.push_back(by < 0 ? 0 : by % 512);
    if (hot_col.size() > 32) begin
      void'(hot_col.pop_front());
      void'(hot_row.pop_front());
    end
    return c;
  endfunction

  // All three x within 60 of one base outside the frame, any y: rows walk but are mostly clipped.
  function automatic raster_cmd_t rand_offscreen_tri();
    int base;
    base = $urandom_range(0, 1) ? $urandom_range(600, 32700) : -$urandom_range(1, 32700);
    return make_tri(base + $urandom_range(0, 60), $signed(16'($urandom)),
                    base + $urandom_range(0, 60), $signed(16'($urandom)),
                    base + $urandom_range(0, 60), $signed(16'($urandom)),
                    $urandom, $urandom, $urandom);
  endfunction

  task automatic test_directed();
    raster_cmd_t c;
    send_item(make_read(0, 0));
    send_item(make_tri(5, 5, 5, 5, 5, 5, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
    send_item(make_read(5, 5));
    send_item(make_tri(10, 20, 14, 20, 12, 20, 32'h0200_0000, 32'h0300_0000, 32'h0400_0000));
    send_item(make_tri(30, 30, 34, 34, 30, 34, 32'h0080_0000, 32'h0300_0000, 32'h0100_0000));
    send_item(make_tri(30, 30, 34, 34, 30, 34, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
    send_item(make_tri(40, 40, 41, 42, 40, 42, 32'd0, 32'd0, 32'd0));
    send_item(make_tri(50, 52, 53, 50, 51, 50, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF));
    send_item(make_tri(510, 509, 515, 513, 508, 514, 32'h0200_0000, 32'h0200_0000,
                       32'h0200_0000));
    send_item(make_tri(-3, -2, 2, 1, -1, 3, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000));
    send_item(make_tri(32767, -32768, 32767, 32767, 32767, 0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_tri(-32768, -32768, -32768, 32767, -32768, 100, 32'h0, 32'h1, 32'h2));
    send_item(make_tri(-32768, -32768, 32767, -20000, 0, -1, 32'h1, 32'h1, 32'h1));
    send_item(make_tri(5, 600, 9, 32767, 7, 1000, 32'h1, 32'h1, 32'h1));
    send_item(make_read(511, 511));
    send_item(make_read(31, 32));
    send_item(make_read(511, 510));
    c = make_read(0, 0);
    c.op = tdr_pkg::CMD_UNUSED;
    send_item(c);
    c.op = tdr_pkg::CMD_CLEAR;
    send_item(c);
    send_item(make_read(31, 32));
    send_item(make_read(5, 5));
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_cycles = 3000;
    hold_seq++;
    for (int i = 0; i < 6; i++)
      send_item(make_read($urandom_range(0, 511), $urandom_range(0, 511)), 1);
  endtask

  task automatic test_random(int n);
    raster_cmd_t c;
    int p, j;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        c = rand_small_tri(3);
      end else if (p < 43) begin
        c = rand_small_tri(14);
      end else if (p < 45) begin
        c = rand_offscreen_tri();
      end else if (p < 48) begin
        c = make_read(0, 0);
        c.op = tdr_pkg::CMD_UNUSED;
      end else if (p < 80 && hot_col.size() > 0) begin
        j = $urandom_range(0, hot_col.size() - 1);
        c = make_read((hot_col[j] + $urandom_range(0, 4)) % 512,
                      (hot_row[j] + $urandom_range(0, 4)) % 512);
      end else begin
        c = make_read($urandom_range(0, 511), $urandom_range(0, 511));
      end
      send_item(c);
    end
  endtask

  initial begin
    mismatches  = 0;
    hold_seq    = 0;
    hold_seen   = 0;
    hold_left   = 0;
    gap_left    = 0;
    hold_cycles = 0;
    width_reg   = 10'd512;
    height_reg  = 10'd512;
    for (int i = 0; i < tdr_pkg::DEPTH; i++) depth_model[i] = tdr_pkg::FAR_DEPTH;
    cmd.valid <= 1'b0;
    cmd.command <= tdr_pkg::CMD_CLEAR;
    cmd.vert_a_x <= '0; cmd.vert_a_y <= '0; cmd.vert_a_invz <= '0;
    cmd.vert_b_x <= '0; cmd.vert_b_y <= '0; cmd.vert_b_invz <= '0;
    cmd.vert_c_x <= '0; cmd.vert_c_y <= '0; cmd.vert_c_invz <= '0;
    cmd.read_col <= '0; cmd.read_row <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= tdr_pkg::CFG_WIDTH;
    cfg.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    set_frame(10'd512, 10'd512);
    test_random(220);
    set_frame(10'd1, 10'd1);
    test_random(150);
    set_frame(10'd1023, 10'd1023);
    test_random(220);
    set_frame(10'd0, 10'd0);
    test_random(150);
    set_frame(10'd37, 10'd300);
    test_random(250);

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
